// ===== sv/byte_stuff_framer_top_assert.svh =====
// Assertion macros used by the framer job queue.
// Both sample on clk and are disabled while arst_n is low.
`ifndef BYTE_STUFF_FRAMER_TOP_ASSERT_SVH
`define BYTE_STUFF_FRAMER_TOP_ASSERT_SVH

// Check that a condition holds at every edge.
`define BSF_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("framer assertion failed");

// Check that a trigger is followed by a condition at the next edge.
`define BSF_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("framer assertion failed");

`endif

// ===== sv/bsf_pkg.sv =====
`timescale 1ns / 1ps
package bsf_pkg;

	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [1:0] REG_DIRECTION = 2'd0;
	localparam logic [1:0] REG_START     = 2'd1;
	localparam logic [1:0] REG_END       = 2'd2;
	localparam logic [1:0] REG_ESCAPE    = 2'd3;

	localparam logic       DIR_TX = 1'b0;
	localparam logic       DIR_RX = 1'b1;

	localparam logic [7:0] START_RESET  = 8'h7E;
	localparam logic [7:0] END_RESET    = 8'h7E;
	localparam logic [7:0] ESCAPE_RESET = 8'h7D;

	// Result slots of one job, emitted lowest first.
	localparam int SLOT_START = 0;
	localparam int SLOT_ESC   = 1;
	localparam int SLOT_DATA  = 2;
	localparam int SLOT_END   = 3;
	localparam int NSLOT      = 4;

	typedef struct packed {
		logic       direction;
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] escape_byte;
		logic       clear;
	} cfg_t;

	typedef struct packed {
		logic             rx;
		logic [NSLOT-1:0] mask;
		logic [7:0]       data;
		logic             bad;
	} job_t;

endpackage

// ===== sv/byte_stuff_framer_top.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake             | words
// config   | in        | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
// input    | in        | in_valid / in_stall   | in_byte, frame_last
// output   | out       | out_valid / out_stall | out_byte, byte_valid, frame_end, frame_bad,
//          |           |                       | run_last
//
// An input word is taken in any cycle while the job queue (four entries) has room.
// The back end sends one output word per cycle from its output register while not
// stalled; an item makes 1 to 4 words in transmit, 0 or 1 in receive. A word in
// flight passes through the queue and then the output register. Reset empties the
// queue, clears the frame state and loads the default delimiters. Output stall
// holds the output register and fills the queue; input stall rises only when the
// queue is full.
module byte_stuff_framer_top
	import bsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              frame_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic              frame_end,
	output logic              frame_bad,
	output logic              run_last
);

	cfg_t cfg;
	job_t push_job;
	job_t head;
	logic push, pop, q_empty, q_full;

	// Register file: direction and the three delimiter words.
	bsf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Front end: track the frame, classify each word into a job of result slots.
	bsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.frame_last (frame_last),
		.q_full     (q_full),
		.push       (push),
		.job        (push_job)
	);

	// Decouple the two sides so each can stall on its own.
	bsf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// Back end: walk the slots of the head job, one output word per cycle while the output is not stalled.
	bsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.frame_end  (frame_end),
		.frame_bad  (frame_bad),
		.run_last   (run_last)
	);

endmodule

// ===== sv/bsf_regs.sv =====
`timescale 1ns / 1ps
module bsf_regs
	import bsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic       direction_q;
	logic [7:0] start_q;
	logic [7:0] end_q;
	logic [7:0] escape_q;
	logic       clear;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	// Clear the frame state at the same edge that writes the direction.
	assign clear  = wr_en && (idx == REG_DIRECTION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_TX;
			start_q     <= START_RESET;
			end_q       <= END_RESET;
			escape_q    <= ESCAPE_RESET;
		end else begin
			if (wr_en) begin
				unique case (idx)
					REG_DIRECTION: direction_q <= pwdata[0];
					REG_START:     start_q     <= pwdata[7:0];
					REG_END:       end_q       <= pwdata[7:0];
					REG_ESCAPE:    escape_q    <= pwdata[7:0];
				endcase
			end
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DIRECTION: prdata[0]   = direction_q;
			REG_START:     prdata[7:0] = start_q;
			REG_END:       prdata[7:0] = end_q;
			REG_ESCAPE:    prdata[7:0] = escape_q;
		endcase
	end

	assign cfg = '{direction: direction_q, start_byte: start_q, end_byte: end_q,
		escape_byte: escape_q, clear: clear};

endmodule

// ===== sv/bsf_front.sv =====
`timescale 1ns / 1ps
module bsf_front
	import bsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       frame_last,
	input  logic       q_full,
	output logic       push,
	output job_t       job
);

	logic inside_q, esc_q, err_q;
	logic inside_d, esc_d, err_d;
	logic accept;
	logic is_start, is_end, is_esc;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_start = (in_byte == cfg.start_byte);
	assign is_end   = (in_byte == cfg.end_byte);
	assign is_esc   = (in_byte == cfg.escape_byte);

	always_comb begin
		job      = '0;
		job.rx   = cfg.direction;
		job.data = in_byte;
		inside_d = inside_q;
		esc_d    = esc_q;
		err_d    = err_q;
		if (cfg.direction == DIR_TX) begin
			job.mask[SLOT_START] = !inside_q;
			job.mask[SLOT_ESC]   = is_start || is_end || is_esc;
			job.mask[SLOT_DATA]  = 1'b1;
			job.mask[SLOT_END]   = frame_last;
			inside_d             = !frame_last;
		end else begin
			priority if (!inside_q) begin
				inside_d = 1'b1;
				esc_d    = 1'b0;
				err_d    = !is_start;
				if (frame_last) begin
					job.mask[SLOT_END] = 1'b1;
					job.bad            = 1'b1;
					inside_d           = 1'b0;
					err_d              = 1'b0;
				end
			end else if (frame_last) begin
				job.mask[SLOT_END] = 1'b1;
				job.bad            = !is_end || esc_q || err_q;
				inside_d           = 1'b0;
				esc_d              = 1'b0;
				err_d              = 1'b0;
			end else if (!err_q) begin
				priority if (esc_q) begin
					esc_d               = 1'b0;
					job.mask[SLOT_DATA] = 1'b1;
				end else if (is_esc) begin
					esc_d = 1'b1;
				end else if (is_start || is_end) begin
					err_d = 1'b1;
				end else begin
					job.mask[SLOT_DATA] = 1'b1;
				end
			end else begin
				// Drop the word: the frame already has an error.
			end
		end
	end

	// Drop items that give no result; they only move the state.
	assign push = accept && (job.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			esc_q    <= 1'b0;
			err_q    <= 1'b0;
		end else if (cfg.clear) begin
			inside_q <= 1'b0;
			esc_q    <= 1'b0;
			err_q    <= 1'b0;
		end else if (accept) begin
			inside_q <= inside_d;
			esc_q    <= esc_d;
			err_q    <= err_d;
		end
	end

endmodule

// ===== sv/bsf_queue.sv =====
`timescale 1ns / 1ps
module bsf_queue
	import bsf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	`include "byte_stuff_framer_top_assert.svh"

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`BSF_ASSERT(a_no_push_full, !(push && full))
	`BSF_ASSERT(a_no_pop_empty, !(pop && empty))
	`BSF_ASSERT_NEXT(a_push_fills, push && !pop, !empty)

endmodule

// ===== sv/bsf_back.sv =====
`timescale 1ns / 1ps
module bsf_back
	import bsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  job_t       head,
	input  logic       q_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       frame_end,
	output logic       frame_bad,
	output logic       run_last
);

	logic [NSLOT-1:0] done_q;
	logic [NSLOT-1:0] rem;
	logic [NSLOT-1:0] sel;
	logic             load;
	logic             is_last;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             byte_valid_q, frame_end_q, frame_bad_q, run_last_q;
	logic [7:0]       nb;
	logic             nbv, nfe, nbad;

	assign rem     = head.mask & ~done_q;
	assign sel     = rem & (~rem + NSLOT'(1));
	assign is_last = ((rem & ~sel) == '0);
	assign load    = !q_empty && (!out_valid_q || !out_stall);
	assign pop     = load && is_last;

	always_comb begin
		nb   = head.data;
		nbv  = 1'b1;
		nfe  = 1'b0;
		nbad = 1'b0;
		priority if (sel[SLOT_START]) begin
			nb = cfg.start_byte;
		end else if (sel[SLOT_ESC]) begin
			nb = cfg.escape_byte;
		end else if (sel[SLOT_DATA]) begin
			nb = head.data;
		end else begin
			nfe  = 1'b1;
			nb   = head.rx ? 8'd0 : cfg.end_byte;
			nbv  = !head.rx;
			nbad = head.rx && head.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				done_q      <= is_last ? '0 : (done_q | sel);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= nb;
			byte_valid_q <= nbv;
			frame_end_q  <= nfe;
			frame_bad_q  <= nbad;
			run_last_q   <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign frame_end  = frame_end_q;
	assign frame_bad  = frame_bad_q;
	assign run_last   = run_last_q;

endmodule
